[src/stepper_ramp_pulse_generator_defines.svh]
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_defines
// Assertion macros shared by the checker files of the stepper ramp block.
// ----------------------------------------------------------------------------
`ifndef STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SRPG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srpg check failed");

// Next-cycle implication, disabled while reset is high.
`define SRPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srpg check failed");

`endif

[src/srpg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg
// Types and constants of the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  localparam int STEPS_PER_UNIT = 1000;
  localparam int STEPS_W        = 26;

  localparam logic [15:0] BASE_PERIOD_RST   = 16'd10000;
  localparam logic [15:0] RAMP_LENGTH_RST   = 16'd6000;
  localparam logic [7:0]  RAMP_INTERVAL_RST = 8'd100;
  localparam logic [7:0]  PERIOD_STEP_RST   = 8'd130;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    REG_BASE_PERIOD,
    REG_RAMP_LENGTH,
    REG_RAMP_INTERVAL,
    REG_PERIOD_STEP
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] base_period;
    logic [15:0] ramp_length;
    logic [7:0]  ramp_interval;
    logic [7:0]  period_step;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [15:0] distance;
    logic        direction;
    logic        stop_request;
  } in_word_t;

  typedef struct packed {
    logic               step_level;
    logic               dir_level;
    logic [15:0]        period;
    logic               running;
    logic               finished;
    logic [STEPS_W-1:0] steps_left;
  } out_word_t;

endpackage

[src/srpg_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_cfg_regs
// Configuration register file, written one register per word.
// ----------------------------------------------------------------------------
module srpg_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  srpg_pkg::cfg_idx_t cfg_index,
  input  logic [15:0]       cfg_data,
  output srpg_pkg::cfg_t    cfg
);
  import srpg_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_period   <= BASE_PERIOD_RST;
      cfg.ramp_length   <= RAMP_LENGTH_RST;
      cfg.ramp_interval <= RAMP_INTERVAL_RST;
      cfg.period_step   <= PERIOD_STEP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_PERIOD:   cfg.base_period   <= cfg_data;
        REG_RAMP_LENGTH:   cfg.ramp_length   <= cfg_data;
        REG_RAMP_INTERVAL: cfg.ramp_interval <= cfg_data[7:0];
        REG_PERIOD_STEP:   cfg.period_step   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[src/srpg_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_core
// Move state and single-pass next-state logic for start and tick words.
// ----------------------------------------------------------------------------
module srpg_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  srpg_pkg::in_word_t  item,
  input  srpg_pkg::cfg_t      cfg,
  output srpg_pkg::out_word_t result
);
  import srpg_pkg::*;

  logic               active, active_next;
  logic               pin_level, pin_level_next;
  logic               edge_count, edge_count_next;
  logic               dir_latch, dir_latch_next;
  logic [STEPS_W-1:0] total_steps, total_steps_next;
  logic [STEPS_W-1:0] remaining, remaining_next;
  logic [7:0]         accel_index, accel_index_next;
  logic [7:0]         decel_index, decel_index_next;
  logic [15:0]        period_reg, period_reg_next;
  logic               fin;

  logic [STEPS_W-1:0] total_load;
  logic [STEPS_W-1:0] rem_new;
  logic [17:0]        ramp_limit;
  logic               ramp_on;
  logic [15:0]        a_prod, d_prod, dec_prod;
  logic [STEPS_W:0]   a_diff;
  logic [16:0]        d_diff, dec_diff;
  logic               a_hit, d_hit;
  logic [8:0]         ai_inc;
  logic [7:0]         ai_dec;
  logic [16:0]        acc_prod;
  logic [17:0]        acc_diff;
  logic [15:0]        acc_period, dec_period;

  // Datapath: marks and period candidates, all from the current state.
  always_comb begin
    total_load = STEPS_W'(item.distance * STEPS_PER_UNIT);
    rem_new    = edge_count ? remaining - STEPS_W'(1) : remaining;
    ramp_limit = {1'b0, cfg.ramp_length, 1'b0} + 18'(cfg.ramp_interval);
    ramp_on    = total_steps > STEPS_W'(ramp_limit);

    a_prod = cfg.ramp_interval * accel_index;
    a_diff = {1'b0, total_steps} - (STEPS_W + 1)'(a_prod);
    a_hit  = !a_diff[STEPS_W] && (rem_new == a_diff[STEPS_W-1:0]) &&
             (({1'b0, rem_new} + (STEPS_W + 1)'(cfg.ramp_length)) >= {1'b0, total_steps});

    d_prod = cfg.ramp_interval * decel_index;
    d_diff = {1'b0, cfg.ramp_length} - {1'b0, d_prod};
    d_hit  = !d_diff[16] && (rem_new == STEPS_W'(d_diff[15:0])) &&
             (rem_new <= STEPS_W'(cfg.ramp_length));

    ai_inc     = {1'b0, accel_index} + 9'd1;
    acc_prod   = cfg.period_step * ai_inc;
    acc_diff   = {2'b00, cfg.base_period} - {1'b0, acc_prod};
    acc_period = acc_diff[17] ? 16'd0 : acc_diff[15:0];

    ai_dec     = accel_index - 8'd1;
    dec_prod   = cfg.period_step * ai_dec;
    dec_diff   = {1'b0, cfg.base_period} - {1'b0, dec_prod};
    dec_period = dec_diff[16] ? 16'd0 : dec_diff[15:0];
  end

  // Next state for the word now being processed.
  always_comb begin
    active_next      = active;
    pin_level_next   = pin_level;
    edge_count_next  = edge_count;
    dir_latch_next   = dir_latch;
    total_steps_next = total_steps;
    remaining_next   = remaining;
    accel_index_next = accel_index;
    decel_index_next = decel_index;
    period_reg_next  = period_reg;
    fin              = 1'b0;
    if (item.op == OP_START) begin
      if (!active) begin
        accel_index_next = '0;
        decel_index_next = '0;
        pin_level_next   = 1'b0;
        dir_latch_next   = item.direction;
        total_steps_next = total_load;
        remaining_next   = total_load;
        period_reg_next  = cfg.base_period;
        active_next      = 1'b1;
      end
    end else if (active) begin
      if (remaining == '0 || item.stop_request) begin
        period_reg_next  = cfg.base_period;
        active_next      = 1'b0;
        total_steps_next = '0;
        remaining_next   = '0;
        accel_index_next = '0;
        decel_index_next = '0;
        fin              = 1'b1;
      end else begin
        pin_level_next  = !pin_level;
        edge_count_next = !edge_count;
        remaining_next  = rem_new;
        if (ramp_on && a_hit) begin
          period_reg_next  = acc_period;
          accel_index_next = ai_inc[7:0];
        end else if (ramp_on && d_hit) begin
          accel_index_next = ai_dec;
          period_reg_next  = dec_period;
          decel_index_next = decel_index + 8'd1;
        end
      end
    end
  end

  always_comb begin
    result.step_level = pin_level_next;
    result.dir_level  = !dir_latch_next;
    result.period     = period_reg_next;
    result.running    = active_next;
    result.finished   = fin;
    result.steps_left = remaining_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      pin_level   <= 1'b0;
      edge_count  <= 1'b0;
      dir_latch   <= 1'b0;
      total_steps <= '0;
      remaining   <= '0;
      accel_index <= '0;
      decel_index <= '0;
      period_reg  <= BASE_PERIOD_RST;
    end else if (fire) begin
      active      <= active_next;
      pin_level   <= pin_level_next;
      edge_count  <= edge_count_next;
      dir_latch   <= dir_latch_next;
      total_steps <= total_steps_next;
      remaining   <= remaining_next;
      accel_index <= accel_index_next;
      decel_index <= decel_index_next;
      period_reg  <= period_reg_next;
    end
  end

endmodule

[src/stepper_ramp_pulse_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator
// Step/direction pulse generator with a trapezoidal speed ramp.
// ----------------------------------------------------------------------------
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   cmd     | cmd_valid/cmd_ready  | cmd: op, distance, direction, stop
//   res     | res_valid/res_ready  | res: step/dir levels, period, status
//   cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// Every command word gives exactly one result word. The accept loads the
// input register, and a later edge, once the result register is free,
// runs the state update and loads the result register. One word per clock
// is sustained while res_ready is high; the state update is the loop.
// Reset (synchronous, rst high) restores the register defaults and idles.
// A stalled result holds the result register; cmd keeps flowing while the
// input register is empty or drains into the result register that cycle.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  srpg_pkg::in_word_t  cmd,
  output logic                res_valid,
  input  logic                res_ready,
  output srpg_pkg::out_word_t res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  srpg_pkg::cfg_idx_t  cfg_index,
  input  logic [15:0]         cfg_data
);
  import srpg_pkg::*;

  // Input register.
  logic      cmd_held;
  in_word_t  cmd_q;
  // Processing strobe: the held word moves into the result register.
  logic      proc;
  cfg_t      cfg;
  out_word_t result;

  assign cfg_ready = 1'b1;
  assign proc      = cmd_held && (!res_valid || res_ready);
  assign cmd_ready = !cmd_held || proc;

  srpg_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srpg_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (proc),
    .item   (cmd_q),
    .cfg    (cfg),
    .result (result)
  );

  // Hold the incoming word until the core takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held <= 1'b0;
    end else if (cmd_ready) begin
      cmd_held <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
  end

  // Result register: load on processing, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res <= result;
    end
  end

endmodule

[src/srpg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_checker
// Port-level checks of the stepper ramp block, bound to the top level.
// ----------------------------------------------------------------------------
`include "stepper_ramp_pulse_generator_defines.svh"

module srpg_checker (
  input logic                clk,
  input logic                rst,
  input logic                res_valid,
  input logic                res_ready,
  input srpg_pkg::out_word_t res
);
  import srpg_pkg::*;

  // A result waiting on the consumer keeps its word.
  `SRPG_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

  // A move that just ended is no longer running.
  `SRPG_ASSERT_NOW(a_fin_idle, clk, rst, res_valid && res.finished, !res.running)

  // Idle means no steps are left.
  `SRPG_ASSERT_NOW(a_idle_empty, clk, rst, res_valid && !res.running, res.steps_left == '0)

  // A finished move reports no steps left.
  `SRPG_ASSERT_NOW(a_fin_zero, clk, rst, res_valid && res.finished, res.steps_left == '0)

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);
